/* rtl/rbb_pkg.sv */
package rbb_pkg;

    // Width of the brick levels and of the price as the arithmetic sees it.
    localparam int PRICE_W      = 32;
    // Fraction bits of the scale register.
    localparam int SCALE_FRAC_W = 16;

    // Fixed field widths of the stream payloads.
    localparam int TICK_W   = 32;
    localparam int SCALE_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int DIR_W    = 2;
    localparam int CLOSE_W  = 32;
    localparam int ACTION_W = 1;

    localparam int OUT_FIELDS_W = COUNT_W + DIR_W + CLOSE_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    // Bit positions of the result fields inside the output tdata.
    localparam int COUNT_LSB = 0;
    localparam int DIR_LSB   = COUNT_LSB + COUNT_W;
    localparam int CLOSE_LSB = DIR_LSB + DIR_W;

    // Product wide enough for any scale format in range before the shift.
    localparam int PROD_W = PRICE_W + SCALE_W + SCALE_FRAC_W;
    // Divider step counter holds the step count itself.
    localparam int STEP_W = $clog2(PRICE_W + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Direction codes, two's complement: +1 up, -1 down, 0 none.
    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

    // Input action codes.
    localparam logic [ACTION_W-1:0] ACT_TICK    = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PRIME,
        ST_DIV,
        ST_FOLLOW,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic               start;
        logic [PRICE_W-1:0] dividend;
        logic [PRICE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [PRICE_W-1:0] quotient;
        logic [PRICE_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic [DIR_W-1:0]   direction;
        logic [CLOSE_W-1:0] close;
    } result_t;

endpackage

/* rtl/rbb_divider.sv */
module rbb_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  rbb_pkg::div_req_t req,
    output rbb_pkg::div_rsp_t rsp
);
    import rbb_pkg::*;

    // Restoring radix-2 divider: one quotient bit per cycle. The dividend is
    // loaded into the quotient register and shifted out from its top while
    // quotient bits shift in at the bottom.
    logic [PRICE_W-1:0] rem_reg, rem_next;
    logic [PRICE_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               done_reg, done_next;
    logic [PRICE_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[PRICE_W-1]};
    assign fits  = trial >= {1'b0, req.divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            step_next = STEP_W'(PRICE_W);
        end
        else if (step_reg != '0)
        begin
            if (fits)
            begin
                rem_next = PRICE_W'(trial - {1'b0, req.divisor});
            end
            else
            begin
                rem_next = PRICE_W'(trial);
            end
            quo_next  = {quo_reg[PRICE_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Packed in the order done, quotient, remainder from the top bit down.
    assign rsp = {done_reg, quo_reg, rem_reg};

endmodule

/* rtl/rbb_seq.sv */
module rbb_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rbb_pkg::ACTION_W-1:0]   in_action,
    input  logic [rbb_pkg::TICK_W-1:0]     in_price,
    input  logic [rbb_pkg::SCALE_W-1:0]    scale,
    output rbb_pkg::result_t               res,
    input  logic                           res_ready
);
    import rbb_pkg::*;

    seq_state_t state_reg, state_next;
    logic       started_reg, started_next;

    logic [PRICE_W-1:0]  high_reg, high_next;
    logic [PRICE_W-1:0]  low_reg, low_next;
    logic [PRICE_W-1:0]  span_reg, span_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [ACTION_W-1:0] action_reg, action_next;
    logic [DIR_W-1:0]    dir_reg, dir_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [PRICE_W-1:0]  close_reg, close_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [PRICE_W:0]   up_sum;
    logic               up_hit;
    logic [PRICE_W-1:0] down_lim;
    logic               down_hit;
    logic [PROD_W-1:0]  product;
    logic [COUNT_W-1:0] count_sat;

    rbb_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign up_sum   = {1'b0, high_reg} + {1'b0, span_reg};
    assign up_hit   = {1'b0, price_reg} >= up_sum;
    assign down_lim = low_reg - span_reg;
    // A down brick needs room below the low; prices never go negative.
    assign down_hit = (low_reg >= span_reg) && (price_reg <= down_lim);
    assign product  = PROD_W'(price_reg) * PROD_W'(scale);
    assign count_sat = (div_rsp.quotient > PRICE_W'(COUNT_MAX)) ?
                       COUNT_MAX : COUNT_W'(div_rsp.quotient);

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        span_next    = span_reg;
        price_next   = price_reg;
        action_next  = action_reg;
        dir_next     = dir_reg;
        count_next   = count_reg;
        close_next   = close_reg;

        in_ready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = price_reg - high_reg;
        div_req.divisor  = span_reg;
        res.valid        = 1'b0;
        res.count        = count_reg;
        res.direction    = dir_reg;
        res.close        = CLOSE_W'(close_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    price_next  = PRICE_W'(in_price);
                    action_next = in_action;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                dir_next   = DIR_NONE;
                count_next = '0;
                close_next = '0;
                state_next = ST_EMIT;
                if (action_reg == ACT_RESTART)
                begin
                    started_next = 1'b0;
                end
                else if (!started_reg)
                begin
                    high_next    = price_reg;
                    low_next     = price_reg;
                    started_next = 1'b1;
                    state_next   = ST_PRIME;
                end
                else if (span_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else if (up_hit)
                begin
                    div_req.start = 1'b1;
                    dir_next      = DIR_UP;
                    state_next    = ST_DIV;
                end
                else if (down_hit)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = low_reg - price_reg;
                    dir_next         = DIR_DOWN;
                    state_next       = ST_DIV;
                end
            end
            ST_PRIME:
            begin
                span_next  = PRICE_W'(product >> SCALE_FRAC_W);
                state_next = ST_EMIT;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    count_next = count_sat;
                    // The level moves by quotient times span, which is the
                    // distance to the price less the remainder.
                    if (dir_reg == DIR_UP)
                    begin
                        high_next = price_reg - div_rsp.remainder;
                    end
                    else
                    begin
                        low_next = price_reg + div_rsp.remainder;
                    end
                    state_next = ST_FOLLOW;
                end
            end
            ST_FOLLOW:
            begin
                if (dir_reg == DIR_UP)
                begin
                    low_next   = high_reg - span_reg;
                    close_next = high_reg;
                end
                else
                begin
                    high_next  = low_reg + span_reg;
                    close_next = low_reg;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        high_reg   <= high_next;
        low_reg    <= low_next;
        span_reg   <= span_next;
        price_reg  <= price_next;
        action_reg <= action_next;
        dir_reg    <= dir_next;
        count_reg  <= count_next;
        close_reg  <= close_next;
    end

endmodule

/* rtl/renko_brick_builder.sv */
// Channel   Direction  Beat contents
// s_axis    in         tuser: action (1 = restart); tdata: tick_price Q24.8
// m_axis    out        tdata: brick_count, brick_direction, brick_close
// cfg       in         cfg_data: brick_scale Q0.16, written without an index
//
// A price tick that completes bricks is evaluated, then runs through the
// shared radix-2 divider (32 quotient bits, one per cycle, then its registered
// done flag); the levels are then placed and the result is handed to the
// output register. Restart and no-brick ticks go from evaluation straight
// to the result; priming ticks first compute the span from their price.
// Reset (rst_n, asynchronous, active low) clears the started flag, the scale
// register and the output valid. The input is ready again once the result
// moves into the output register, so a stalled output holds at most one
// result while the next tick is taken.
module renko_brick_builder (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] tick_price
    input  logic [rbb_pkg::TICK_W-1:0]        s_axis_tdata,
    // [0] action
    input  logic [rbb_pkg::ACTION_W-1:0]      s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] brick_count, [17:16] brick_direction, [49:18] brick_close,
    // [55:50] zero
    output logic [rbb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbb_pkg::SCALE_W-1:0]       cfg_data
);
    import rbb_pkg::*;

    logic [SCALE_W-1:0]    scale_reg, scale_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    result_t               res;
    logic                  res_ready;

    // The user changes scale only between items; not enforced, always accepted.
    assign cfg_ready = 1'b1;

    rbb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_price  (s_axis_tdata),
        .scale     (scale_reg),
        .res       (res),
        .res_ready (res_ready)
    );

    // The output register takes a new result when empty or being drained.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        scale_next = scale_reg;
        if (cfg_valid && cfg_ready)
        begin
            scale_next = cfg_data;
        end

        out_valid_next = (res.valid && res_ready) || (out_valid_reg && !m_axis_tready);
        out_data_next  = out_data_reg;
        if (res.valid && res_ready)
        begin
            out_data_next = {{OUT_PAD_W{1'b0}}, res.close, res.direction, res.count};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scale_reg     <= scale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* rtl/rbb_checker.sv */
module rbb_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [rbb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import rbb_pkg::*;

    logic [COUNT_W-1:0] count_f;
    logic [DIR_W-1:0]   dir_f;
    logic [CLOSE_W-1:0] close_f;

    assign count_f = m_axis_tdata[COUNT_LSB +: COUNT_W];
    assign dir_f   = m_axis_tdata[DIR_LSB +: DIR_W];
    assign close_f = m_axis_tdata[CLOSE_LSB +: CLOSE_W];

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (dir_f == DIR_NONE || dir_f == DIR_UP || dir_f == DIR_DOWN))
        else $error("illegal brick direction");

    a_no_brick: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dir_f == DIR_NONE |-> count_f == '0 && close_f == '0)
        else $error("no-brick result carries a count or close");

    a_brick_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dir_f != DIR_NONE |-> count_f != '0)
        else $error("brick result with zero count");

endmodule

bind renko_brick_builder rbb_checker u_rbb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb_renko_brick_builder.sv */
`timescale 1ns / 1ps

// Self-checking bench for the Renko brick builder.
module tb_renko_brick_builder;

    import rbb_pkg::*;

    // One input beat as the bench sees it: the action travels on tuser,
    // the price on tdata.
    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [TICK_W-1:0]   price;
    } tick_t;

    // The fields of one result beat.
    typedef struct {
        logic [COUNT_W-1:0] count;
        logic [DIR_W-1:0]   direction;
        logic [CLOSE_W-1:0] close;
    } brick_t;

    localparam logic [63:0] LEVEL_MASK = (64'd1 << PRICE_W) - 64'd1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] tick_price
    logic [TICK_W-1:0]      s_axis_tdata = '0;
    // [0] action
    logic [ACTION_W-1:0]    s_axis_tuser = ACT_TICK;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [15:0] brick_count, [17:16] brick_direction, [49:18] brick_close,
    // [55:50] zero
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [SCALE_W-1:0]     cfg_data = '0;

    renko_brick_builder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ticks waiting to be driven, and bricks waiting to come out, oldest first.
    tick_t  pending_ticks[$];
    brick_t expected_bricks[$];

    int     ticks_queued = 0;
    int     results_seen = 0;
    int     fail_count = 0;

    // Tracked copy of the block's state. The scale copy is updated by the
    // stimulus process whenever a configuration beat completes.
    logic            trk_started = 1'b0;
    logic [63:0]     trk_high = '0;
    logic [63:0]     trk_low = '0;
    logic [63:0]     trk_span = '0;
    logic [SCALE_W-1:0] trk_scale = '0;

    // Applies one accepted tick to the tracked state and returns the brick
    // result that the block must produce for it. A restart, the priming tick
    // and any tick that stays inside the current brick all give a zero result.
    function automatic brick_t advance_bricks(input tick_t tk);
        brick_t      res;
        logic [63:0] px;
        logic [63:0] quot;
        px = {32'd0, tk.price} & LEVEL_MASK;
        quot = '0;
        res.count = '0;
        res.direction = DIR_NONE;
        res.close = '0;
        if (tk.action == ACT_RESTART)
        begin
            trk_started = 1'b0;
            trk_high = '0;
            trk_low = '0;
            trk_span = '0;
        end
        else if (!trk_started)
        begin
            // The span is a truncated fraction of the priming price.
            trk_high = px;
            trk_low = px;
            trk_span = ((px * {48'd0, trk_scale}) >> SCALE_FRAC_W) & LEVEL_MASK;
            trk_started = 1'b1;
        end
        else if (trk_span != 0)
        begin
            // Up moves win; after one the down test cannot hold anyway.
            if (px >= trk_high + trk_span)
            begin
                quot = (px - trk_high) / trk_span;
                trk_high = (trk_high + quot * trk_span) & LEVEL_MASK;
                trk_low = trk_high - trk_span;
                res.direction = DIR_UP;
                res.close = trk_high[CLOSE_W-1:0];
            end
            else if (trk_low >= trk_span && px <= trk_low - trk_span)
            begin
                quot = (trk_low - px) / trk_span;
                trk_low = trk_low - quot * trk_span;
                trk_high = (trk_low + trk_span) & LEVEL_MASK;
                res.direction = DIR_DOWN;
                res.close = trk_low[CLOSE_W-1:0];
            end
        end
        // The count saturates, but the levels above moved by the full quotient.
        res.count = (quot > {48'd0, COUNT_MAX}) ? COUNT_MAX : quot[COUNT_W-1:0];
        return res;
    endfunction

    // Sender: bursts of random length separated by random gaps. A gap of zero
    // lets two bursts run together, which gives stretches with no idling.
    tick_t  tick_on_bus;
    brick_t accepted_brick;
    int     burst_left = 0;
    int     gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= ACT_TICK;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                accepted_brick = advance_bricks(tick_on_bus);
                expected_bricks.push_back(accepted_brick);
            end
            // The bus is free for a new beat once the current one is gone.
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    tick_on_bus = pending_ticks.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= tick_on_bus.price;
                    s_axis_tuser <= tick_on_bus.action;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: tready follows one of several stall modes, each held for a
    // random stretch of cycles: always ready, coin flip, mostly stalled, or
    // a repeating 8-bit pattern drawn at random.
    int          stall_mode = 0;
    int          stall_run = 0;
    int          stall_phase = 0;
    logic [7:0]  stall_pattern = 8'hFF;
    brick_t      oldest_brick;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_bricks.size() == 0)
                begin
                    $error("result beat with no brick expected: tdata %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    oldest_brick = expected_bricks.pop_front();
                    if (m_axis_tdata[COUNT_LSB +: COUNT_W] !== oldest_brick.count)
                    begin
                        $error("brick_count: expected %0d, actual %0d",
                               oldest_brick.count, m_axis_tdata[COUNT_LSB +: COUNT_W]);
                        fail_count++;
                    end
                    if (m_axis_tdata[DIR_LSB +: DIR_W] !== oldest_brick.direction)
                    begin
                        $error("brick_direction: expected %b, actual %b",
                               oldest_brick.direction, m_axis_tdata[DIR_LSB +: DIR_W]);
                        fail_count++;
                    end
                    if (m_axis_tdata[CLOSE_LSB +: CLOSE_W] !== oldest_brick.close)
                    begin
                        $error("brick_close: expected %h, actual %h",
                               oldest_brick.close, m_axis_tdata[CLOSE_LSB +: CLOSE_W]);
                        fail_count++;
                    end
                    if (m_axis_tdata[OUT_DATA_W-1:CLOSE_LSB+CLOSE_W] !== '0)
                    begin
                        $error("tdata padding: expected 0, actual %h",
                               m_axis_tdata[OUT_DATA_W-1:CLOSE_LSB+CLOSE_W]);
                        fail_count++;
                    end
                end
            end

            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_run = $urandom_range(16, 200);
                stall_pattern = 8'($urandom_range(1, 255));
            end
            else
            begin
                stall_run--;
            end
            stall_phase = (stall_phase + 1) % 8;
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= stall_pattern[stall_phase];
            endcase
        end
    end

    // Stimulus side: what the generator believes the current brick size and
    // last price are, so that random walks move by whole bricks.
    logic [SCALE_W-1:0] gen_scale = '0;
    logic               gen_primed = 1'b0;
    longint             gen_span = 0;
    longint             gen_last = 0;

    task automatic push_tick(input logic [ACTION_W-1:0] action, input logic [TICK_W-1:0] price);
        tick_t tk;
        tk.action = action;
        tk.price = price;
        pending_ticks.push_back(tk);
        ticks_queued++;
    endtask

    // Waits until every queued tick has produced its result, then lets the
    // block settle for longer than its slowest tick.
    task automatic wait_drained();
        while (results_seen < ticks_queued)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Writes the scale register while the block is idle.
    task automatic write_scale(input logic [SCALE_W-1:0] value);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        trk_scale = value;
        gen_scale = value;
    endtask

    // Mostly restart-prime-walk sequences whose steps are whole bricks, with
    // some random jitter, rare huge jumps, and a share of arbitrary prices.
    task automatic queue_random_ticks(input int n);
        int      roll;
        longint  step;
        longint  nxt;
        logic [TICK_W-1:0] px;
        push_tick(ACT_RESTART, $urandom);
        gen_primed = 1'b0;
        for (int i = 1; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                push_tick(ACT_RESTART, $urandom);
                gen_primed = 1'b0;
            end
            else if (!gen_primed)
            begin
                px = $urandom >> $urandom_range(0, 20);
                gen_span = (longint'(px) * longint'(gen_scale)) >>> SCALE_FRAC_W;
                gen_last = longint'(px);
                gen_primed = 1'b1;
                push_tick(ACT_TICK, px);
            end
            else if (roll < 15)
            begin
                push_tick(ACT_TICK, $urandom);
            end
            else
            begin
                if (gen_span == 0)
                    step = longint'($urandom_range(0, 4096));
                else if ($urandom_range(0, 19) == 0)
                    step = gen_span * longint'($urandom_range(7, 100000));
                else
                    step = gen_span * longint'($urandom_range(0, 6));
                // A quarter of the steps land exactly on a brick boundary.
                if (gen_span != 0 && $urandom_range(0, 3) != 0)
                    step = step + longint'($urandom_range(0, 32'(gen_span - 1)));
                nxt = $urandom_range(0, 1) ? gen_last + step : gen_last - step;
                if (nxt < 0)
                    nxt = 0;
                if (nxt > longint'(32'hFFFF_FFFF))
                    nxt = longint'(32'hFFFF_FFFF);
                gen_last = nxt;
                push_tick(ACT_TICK, nxt[TICK_W-1:0]);
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scale still at its reset value of zero: the span is zero, so no
        // tick can ever form a brick.
        push_tick(ACT_TICK, 32'h1234_5678);
        push_tick(ACT_TICK, 32'hFFFF_FFFF);
        push_tick(ACT_TICK, 32'h0000_0000);
        push_tick(ACT_RESTART, 32'h0000_0000);

        // Smallest nonzero scale: a span of 16 against a full-range jump makes
        // the count saturate in both directions. The down move then leaves
        // the low at zero, where no further down brick fits, and the last
        // ticks make one brick up and one brick down, each exactly at its boundary.
        write_scale(16'h0001);
        push_tick(ACT_RESTART, 32'hFFFF_FFFF);
        push_tick(ACT_TICK, 32'h0010_0000);
        push_tick(ACT_TICK, 32'hFFFF_FFFF);
        push_tick(ACT_TICK, 32'h0000_0000);
        push_tick(ACT_TICK, 32'h0000_0000);
        push_tick(ACT_TICK, 32'h0000_0020);
        push_tick(ACT_TICK, 32'h0000_001F);
        push_tick(ACT_TICK, 32'h0000_0000);
        push_tick(ACT_RESTART, 32'h0000_0000);

        // Largest scale: the span is nearly the whole price range, one down
        // brick lands exactly on its boundary, then the low sits below a span.
        write_scale(16'hFFFF);
        push_tick(ACT_RESTART, 32'h0000_0000);
        push_tick(ACT_TICK, 32'hFFFF_FFFF);
        push_tick(ACT_TICK, 32'h0001_0000);
        push_tick(ACT_TICK, 32'hFFFF_FFFF);
        push_tick(ACT_TICK, 32'h0000_0000);

        // Half scale: one up brick, then a two-brick drop to zero.
        write_scale(16'h8000);
        push_tick(ACT_RESTART, 32'h0000_0000);
        push_tick(ACT_TICK, 32'h0000_0100);
        push_tick(ACT_TICK, 32'h0000_0180);
        push_tick(ACT_TICK, 32'h0000_0000);

        // Random part: the extremes of the scale first, then random scales
        // spread over several orders of magnitude.
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: write_scale(16'hFFFF);
                1: write_scale(16'h0001);
                2: write_scale(16'h0000);
                default: write_scale(16'($urandom_range(0, 65535) >> $urandom_range(0, 14)));
            endcase
            queue_random_ticks(93);
        end

        wait_drained();
        if (expected_bricks.size() != 0)
        begin
            $error("%0d expected bricks never came out", expected_bricks.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
